FILE: src/preamble_length_checksum_deframer_defines.svh
// Assertion macros shared by the deframer's checker.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef PREAMBLE_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH
`define PREAMBLE_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PLCD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, disabled while reset is held.
`define PLCD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

FILE: src/plcd_pkg.sv
// Types, codes and constants for the preamble/length/checksum deframer.
// Used by plcd_parser, the top level and the checker; depends on nothing.
`default_nettype none

package plcd_pkg;

    typedef enum logic [1:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_HEADER,
        PH_BODY
    } phase_t;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM = 2'd1;
    localparam logic [1:0] STATUS_SHORT   = 2'd2;

    localparam logic [7:0] PREAMBLE_0         = 8'h02;
    localparam logic [7:0] PREAMBLE_1         = 8'h01;
    localparam logic [7:0] SUM_SEED           = 8'h03;  // 0x02 + 0x01
    localparam logic [7:0] MIN_FRAME          = 8'd15;
    localparam logic [7:0] IDLE_SAT           = 8'hFF;
    localparam logic [7:0] IDLE_TIMEOUT_RESET = 8'd10;

    localparam logic [7:0] POS_LENGTH     = 8'd2;
    localparam logic [7:0] POS_DEST_FIRST = 8'd4;
    localparam logic [7:0] POS_DEST_LAST  = 8'd7;
    localparam logic [7:0] POS_SRC_FIRST  = 8'd8;
    localparam logic [7:0] POS_SRC_LAST   = 8'd11;
    localparam logic [7:0] POS_CMD_FIRST  = 8'd12;
    localparam logic [7:0] POS_CMD_LAST   = 8'd13;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [1:0]  status;
        logic [31:0] dest_addr;
        logic [31:0] source_addr;
        logic [15:0] command_word;
        logic [7:0]  payload_len;
        logic        last;
    } out_item_t;

endpackage

`default_nettype wire

FILE: src/plcd_parser.sv
// Frame parser: preamble hunt, header capture, checksum and idle timeout.
// Holds the frame state and produces at most one result per accepted item.
// Depends on plcd_pkg.
`default_nettype none

module plcd_parser (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                item_fire,
    input  wire plcd_pkg::in_item_t  item,
    input  wire logic [7:0]          idle_timeout,
    output logic                     res_valid,
    output plcd_pkg::out_item_t      res
);

    plcd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  idle_reg, idle_next;
    logic [31:0] dest_reg, dest_next;
    logic [31:0] src_reg, src_next;
    logic [15:0] cmdw_reg, cmdw_next;

    logic       is_tick;
    logic [7:0] b;
    logic [7:0] idle_inc;
    logic       timeout_hit;
    logic       short_len;
    logic       body_end;

    assign is_tick     = (item.cmd == plcd_pkg::CMD_TICK);
    assign b           = item.rx_byte;
    assign idle_inc    = (idle_reg == plcd_pkg::IDLE_SAT) ? idle_reg : idle_reg + 8'd1;
    assign timeout_hit = (idle_inc >= idle_timeout);
    assign short_len   = (b < plcd_pkg::MIN_FRAME);
    // Checksum byte is the one at position length-1
    assign body_end    = ({1'b0, pos_reg} + 9'd1) >= {1'b0, len_reg};

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (item_fire) begin
            if (is_tick) begin
                if (phase_reg != plcd_pkg::PH_HUNT1 && timeout_hit) begin
                    phase_next = plcd_pkg::PH_HUNT1;
                end
            end else begin
                case (phase_reg)
                    plcd_pkg::PH_HUNT1: begin
                        if (b == plcd_pkg::PREAMBLE_0) begin
                            phase_next = plcd_pkg::PH_HUNT2;
                        end
                    end
                    plcd_pkg::PH_HUNT2: begin
                        if (b == plcd_pkg::PREAMBLE_1) begin
                            phase_next = plcd_pkg::PH_HEADER;
                        end else if (b != plcd_pkg::PREAMBLE_0) begin
                            phase_next = plcd_pkg::PH_HUNT1;
                        end
                    end
                    plcd_pkg::PH_HEADER: begin
                        if (pos_reg == plcd_pkg::POS_LENGTH && short_len) begin
                            phase_next = plcd_pkg::PH_HUNT1;
                        end else if (pos_reg >= plcd_pkg::POS_CMD_LAST) begin
                            phase_next = plcd_pkg::PH_BODY;
                        end
                    end
                    plcd_pkg::PH_BODY: begin
                        if (body_end) begin
                            phase_next = plcd_pkg::PH_HUNT1;
                        end
                    end
                    default: begin
                        phase_next = plcd_pkg::PH_HUNT1;
                    end
                endcase
            end
        end
    end

    // Datapath and result
    always_comb begin
        pos_next  = pos_reg;
        len_next  = len_reg;
        sum_next  = sum_reg;
        idle_next = idle_reg;
        dest_next = dest_reg;
        src_next  = src_reg;
        cmdw_next = cmdw_reg;
        res_valid = 1'b0;
        res       = '0;
        if (item_fire) begin
            if (is_tick) begin
                if (phase_reg != plcd_pkg::PH_HUNT1) begin
                    idle_next = timeout_hit ? 8'd0 : idle_inc;
                end
            end else begin
                idle_next = 8'd0;
                case (phase_reg)
                    plcd_pkg::PH_HUNT2: begin
                        if (b == plcd_pkg::PREAMBLE_1) begin
                            pos_next = plcd_pkg::POS_LENGTH;
                            sum_next = plcd_pkg::SUM_SEED;
                        end
                    end
                    plcd_pkg::PH_HEADER: begin
                        sum_next = sum_reg + b;
                        pos_next = pos_reg + 8'd1;
                        if (pos_reg == plcd_pkg::POS_LENGTH) begin
                            len_next = b;
                            if (short_len) begin
                                res_valid  = 1'b1;
                                res.kind   = plcd_pkg::KIND_VERDICT;
                                res.status = plcd_pkg::STATUS_SHORT;
                                res.last   = 1'b1;
                            end
                        end
                        if (pos_reg inside {[plcd_pkg::POS_DEST_FIRST:plcd_pkg::POS_DEST_LAST]}) begin
                            dest_next = {dest_reg[23:0], b};
                        end
                        if (pos_reg inside {[plcd_pkg::POS_SRC_FIRST:plcd_pkg::POS_SRC_LAST]}) begin
                            src_next = {src_reg[23:0], b};
                        end
                        if (pos_reg inside {[plcd_pkg::POS_CMD_FIRST:plcd_pkg::POS_CMD_LAST]}) begin
                            cmdw_next = {cmdw_reg[7:0], b};
                        end
                    end
                    plcd_pkg::PH_BODY: begin
                        res_valid = 1'b1;
                        if (body_end) begin
                            res.kind         = plcd_pkg::KIND_VERDICT;
                            res.status       = (b == sum_reg) ? plcd_pkg::STATUS_OK
                                                              : plcd_pkg::STATUS_BAD_SUM;
                            res.dest_addr    = dest_reg;
                            res.source_addr  = src_reg;
                            res.command_word = cmdw_reg;
                            res.payload_len  = len_reg - plcd_pkg::MIN_FRAME;
                            res.last         = 1'b1;
                        end else begin
                            sum_next         = sum_reg + b;
                            pos_next         = pos_reg + 8'd1;
                            res.kind         = plcd_pkg::KIND_PAYLOAD;
                            res.payload_byte = b;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= plcd_pkg::PH_HUNT1;
            pos_reg   <= 8'd0;
            sum_reg   <= 8'd0;
            idle_reg  <= 8'd0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            idle_reg  <= idle_next;
        end
    end

    // Header fields are always fully written before they are read
    always_ff @(posedge aclk) begin
        len_reg  <= len_next;
        dest_reg <= dest_next;
        src_reg  <= src_next;
        cmdw_reg <= cmdw_next;
    end

endmodule

`default_nettype wire

FILE: src/preamble_length_checksum_deframer.sv
// Top level of the preamble/length/checksum deframer.
// Instantiates plcd_parser; depends on plcd_pkg.
//
// Usage:
//   s_valid/s_ready/s_data carry one item per transfer: a received byte
//   (cmd = byte) or one time tick (cmd = tick). Frames start with 0x02 0x01,
//   byte 2 is the total length, then destination, source and command words.
//   m_valid/m_ready/m_data carry results: each payload byte as it arrives,
//   then one verdict (last = 1) with header fields and status ok or checksum
//   mismatch, or a short verdict for length below 15. Other items give none.
//   cfg_valid/cfg_ready/cfg_data write the idle timeout in ticks; cfg_ready
//   is always high. Write it only while the block is idle.
//   A result is registered and on m_data in the cycle after its transfer.
//   Throughput: one item per cycle while the output is not stalled, set by
//   the single parser pass feeding the output register.
//   Stall: while m_valid is high and m_ready low, s_ready drops; the pending
//   result holds. s_ready is high whenever the output register is empty or
//   being drained in the same cycle.
//   Reset: aresetn low for one cycle returns to the preamble hunt, empties
//   the output register and sets the idle timeout back to 10 ticks.
`default_nettype none

module preamble_length_checksum_deframer (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire plcd_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output plcd_pkg::out_item_t      m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [7:0]          cfg_data
);

    logic [7:0]          timeout_reg, timeout_next;
    logic                m_valid_reg, m_valid_next;
    plcd_pkg::out_item_t m_data_reg, m_data_next;
    logic                s_fire;
    logic                res_valid;
    plcd_pkg::out_item_t res;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    plcd_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_fire    (s_fire),
        .item         (s_data),
        .idle_timeout (timeout_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    always_comb begin
        timeout_next = timeout_reg;
        if (cfg_valid) begin
            timeout_next = cfg_data;
        end
    end

    // Load a new result, or drop the old one once it has been taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (s_fire && res_valid) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= plcd_pkg::IDLE_TIMEOUT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            timeout_reg <= timeout_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

FILE: src/plcd_checker.sv
// Port-level checks on the deframer's result channel, bound to the top level.
// Depends on plcd_pkg and preamble_length_checksum_deframer_defines.svh.
`default_nettype none
`include "preamble_length_checksum_deframer_defines.svh"

module plcd_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire plcd_pkg::out_item_t m_data
);

    // A stalled result stays offered
    `PLCD_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_valid && !m_ready, m_valid)

    // Only a verdict closes a frame
    `PLCD_ASSERT_NOW(a_last_is_verdict, aclk, aresetn, m_valid, m_data.last == (m_data.kind == plcd_pkg::KIND_VERDICT))

    // Payload transfers carry a zero status, payload length and destination address
    `PLCD_ASSERT_NOW(a_payload_clean, aclk, aresetn, m_valid && m_data.kind == plcd_pkg::KIND_PAYLOAD, m_data.status == plcd_pkg::STATUS_OK && m_data.payload_len == 8'd0 && m_data.dest_addr == 32'd0)

    // Short frames report a zero payload length, source address and command word
    `PLCD_ASSERT_NOW(a_short_empty, aclk, aresetn, m_valid && m_data.status == plcd_pkg::STATUS_SHORT, m_data.payload_len == 8'd0 && m_data.source_addr == 32'd0 && m_data.command_word == 16'd0)

endmodule

bind preamble_length_checksum_deframer plcd_checker u_plcd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for preamble_length_checksum_deframer.
// Depends on plcd_pkg and the deframer RTL; drives random and directed
// framed byte and tick streams and checks every result against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PAUSE_EVERY = 500;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    plcd_pkg::in_item_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    plcd_pkg::out_item_t m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [7:0]          cfg_data  = '0;

    preamble_length_checksum_deframer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Stimulus and expectation stores
    plcd_pkg::in_item_t  rx_items[$];
    plcd_pkg::out_item_t awaited_out[$];

    // Predictor state
    plcd_pkg::phase_t hunt_phase  = plcd_pkg::PH_HUNT1;
    logic [7:0]       frame_pos   = '0;
    logic [7:0]       frame_len   = '0;
    logic [7:0]       frame_sum   = '0;
    logic [31:0]      hdr_dest    = '0;
    logic [31:0]      hdr_source  = '0;
    logic [15:0]      hdr_command = '0;
    logic [7:0]       idle_ticks  = '0;
    logic [7:0]       idle_limit  = plcd_pkg::IDLE_TIMEOUT_RESET;

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int gen_timeout   = plcd_pkg::IDLE_TIMEOUT_RESET;
    int queued_items  = 0;
    int errors        = 0;
    int cycles        = 0;
    int n_in          = 0;
    int n_payload     = 0;
    int n_ok          = 0;
    int n_bad_sum     = 0;
    int n_short       = 0;
    int last_timeout  = 0;

    logic s_took = 1'b0;

    task automatic restart_hunt();
        hunt_phase  = plcd_pkg::PH_HUNT1;
        frame_pos   = '0;
        frame_len   = '0;
        frame_sum   = '0;
        hdr_dest    = '0;
        hdr_source  = '0;
        hdr_command = '0;
        idle_ticks  = '0;
    endtask

    task automatic deframe_step(plcd_pkg::in_item_t it);
        plcd_pkg::out_item_t r;
        logic [7:0]          b;
        r = '0;
        b = it.rx_byte;
        if (it.cmd == plcd_pkg::CMD_TICK) begin
            if (hunt_phase != plcd_pkg::PH_HUNT1) begin
                if (idle_ticks < plcd_pkg::IDLE_SAT)
                    idle_ticks = idle_ticks + 8'd1;
                if (idle_ticks >= idle_limit)
                    restart_hunt();
            end
        end else begin
            idle_ticks = '0;
            case (hunt_phase)
                plcd_pkg::PH_HUNT1: begin
                    if (b == plcd_pkg::PREAMBLE_0)
                        hunt_phase = plcd_pkg::PH_HUNT2;
                end
                plcd_pkg::PH_HUNT2: begin
                    if (b == plcd_pkg::PREAMBLE_1) begin
                        hunt_phase = plcd_pkg::PH_HEADER;
                        frame_pos  = plcd_pkg::POS_LENGTH;
                        frame_sum  = plcd_pkg::SUM_SEED;
                    end else if (b != plcd_pkg::PREAMBLE_0) begin
                        hunt_phase = plcd_pkg::PH_HUNT1;
                    end
                end
                plcd_pkg::PH_HEADER: begin
                    frame_sum = frame_sum + b;
                    if (frame_pos == plcd_pkg::POS_LENGTH && b < plcd_pkg::MIN_FRAME) begin
                        r.kind   = plcd_pkg::KIND_VERDICT;
                        r.status = plcd_pkg::STATUS_SHORT;
                        r.last   = 1'b1;
                        awaited_out.push_back(r);
                        restart_hunt();
                    end else begin
                        if (frame_pos == plcd_pkg::POS_LENGTH)
                            frame_len = b;
                        else if (frame_pos >= plcd_pkg::POS_DEST_FIRST &&
                                 frame_pos <= plcd_pkg::POS_DEST_LAST)
                            hdr_dest = {hdr_dest[23:0], b};
                        else if (frame_pos >= plcd_pkg::POS_SRC_FIRST &&
                                 frame_pos <= plcd_pkg::POS_SRC_LAST)
                            hdr_source = {hdr_source[23:0], b};
                        else if (frame_pos >= plcd_pkg::POS_CMD_FIRST &&
                                 frame_pos <= plcd_pkg::POS_CMD_LAST)
                            hdr_command = {hdr_command[7:0], b};
                        if (frame_pos >= plcd_pkg::POS_CMD_LAST)
                            hunt_phase = plcd_pkg::PH_BODY;
                        frame_pos = frame_pos + 8'd1;
                    end
                end
                default: begin
                    // the byte at length - 1 carries the checksum
                    if ({1'b0, frame_pos} + 9'd1 >= {1'b0, frame_len}) begin
                        r.kind         = plcd_pkg::KIND_VERDICT;
                        r.status       = (b == frame_sum) ? plcd_pkg::STATUS_OK
                                                          : plcd_pkg::STATUS_BAD_SUM;
                        r.dest_addr    = hdr_dest;
                        r.source_addr  = hdr_source;
                        r.command_word = hdr_command;
                        r.payload_len  = frame_len - plcd_pkg::MIN_FRAME;
                        r.last         = 1'b1;
                        awaited_out.push_back(r);
                        restart_hunt();
                    end else begin
                        frame_sum      = frame_sum + b;
                        frame_pos      = frame_pos + 8'd1;
                        r.kind         = plcd_pkg::KIND_PAYLOAD;
                        r.payload_byte = b;
                        awaited_out.push_back(r);
                    end
                end
            endcase
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    task automatic compare_result(plcd_pkg::out_item_t want, plcd_pkg::out_item_t got);
        check_field("kind", want.kind, got.kind);
        check_field("payload_byte", want.payload_byte, got.payload_byte);
        check_field("status", want.status, got.status);
        check_field("dest_addr", want.dest_addr, got.dest_addr);
        check_field("source_addr", want.source_addr, got.source_addr);
        check_field("command_word", want.command_word, got.command_word);
        check_field("payload_len", want.payload_len, got.payload_len);
        check_field("last", want.last, got.last);
        if (want.kind == plcd_pkg::KIND_PAYLOAD)
            n_payload++;
        else if (want.status == plcd_pkg::STATUS_OK)
            n_ok++;
        else if (want.status == plcd_pkg::STATUS_BAD_SUM)
            n_bad_sum++;
        else
            n_short++;
    endtask

    // Check the result side first, then predict from the input transfer
    always @(posedge aclk) begin : monitor
        plcd_pkg::out_item_t want;
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            s_took <= aresetn && s_valid && s_ready;
            if (aresetn) begin
                if (m_valid && m_ready) begin
                    if (awaited_out.size() == 0) begin
                        $error("unexpected result: kind %0h last %0h", m_data.kind,
                               m_data.last);
                        errors++;
                    end else begin
                        want = awaited_out.pop_front();
                        compare_result(want, m_data);
                    end
                end
                if (cfg_valid && cfg_ready)
                    idle_limit = cfg_data;
                if (s_valid && s_ready) begin
                    n_in++;
                    deframe_step(s_data);
                end
            end
        end
    end

    // Driver: one transfer per handshake, with random gaps and a drain pause
    int  launched      = 0;
    int  next_pause_at = PAUSE_EVERY / 2;
    bit  drain_pause   = 1'b0;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        if (aresetn && (!s_valid || s_took)) begin
            if (drain_pause) begin
                s_valid <= 1'b0;
                if (awaited_out.size() == 0)
                    drain_pause = 1'b0;
            end else if (rx_items.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                if (launched == next_pause_at) begin
                    // hold off until every outstanding result has drained
                    drain_pause   = 1'b1;
                    next_pause_at = next_pause_at + PAUSE_EVERY;
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_data  <= rx_items.pop_front();
                    launched++;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    task automatic push_byte(logic [7:0] b);
        plcd_pkg::in_item_t it;
        it.cmd     = plcd_pkg::CMD_BYTE;
        it.rx_byte = b;
        rx_items.push_back(it);
        queued_items++;
    endtask

    task automatic push_ticks(int n);
        plcd_pkg::in_item_t it;
        for (int i = 0; i < n; i++) begin
            it.cmd     = plcd_pkg::CMD_TICK;
            it.rx_byte = 8'($urandom_range(0, 255));
            rx_items.push_back(it);
            queued_items++;
        end
    endtask

    task automatic push_gap(int tmo);
        int cap;
        cap = (tmo > 7) ? 6 : tmo - 1;
        if (cap > 0 && $urandom_range(0, 9) == 0)
            push_ticks($urandom_range(1, cap));
    endtask

    task automatic queue_frame(int tmo);
        logic [7:0] fb[$];
        logic [7:0] len;
        logic [7:0] sum;
        int         sel;
        int         drop_at;
        int         drop_len;
        sel      = $urandom_range(0, 19);
        drop_at  = -1;
        drop_len = 0;
        if (sel == 0)
            len = plcd_pkg::MIN_FRAME;
        else if (sel == 1)
            len = 8'hFF;
        else if (sel == 2)
            len = 8'($urandom_range(41, 254));
        else
            len = 8'($urandom_range(16, 40));
        if ($urandom_range(0, 4) == 0)
            for (int i = $urandom_range(1, 3); i > 0; i--)
                push_byte(plcd_pkg::PREAMBLE_0);
        fb = {plcd_pkg::PREAMBLE_0, plcd_pkg::PREAMBLE_1, len, 8'($urandom_range(0, 255))};
        for (int i = 0; i < 10 + len - plcd_pkg::MIN_FRAME; i++)
            fb.push_back(8'($urandom_range(0, 255)));
        sum = '0;
        foreach (fb[i])
            sum = sum + fb[i];
        if ($urandom_range(0, 6) == 0)
            sum = sum + 8'($urandom_range(1, 255));
        fb.push_back(sum);
        if ($urandom_range(0, 24) == 0) begin
            drop_at  = $urandom_range(1, fb.size() - 1);
            drop_len = $urandom_range(0, 1) ? tmo : tmo - 1;
        end
        foreach (fb[i]) begin
            if (i == drop_at)
                push_ticks(drop_len);
            else if (i > 0)
                push_gap(tmo);
            push_byte(fb[i]);
        end
    endtask

    task automatic queue_random(int budget, int tmo);
        int stop_at;
        int r;
        stop_at = queued_items + budget;
        while (queued_items < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                queue_frame(tmo);
            end else if (r < 78) begin
                push_byte(plcd_pkg::PREAMBLE_0);
                push_byte(plcd_pkg::PREAMBLE_1);
                push_byte(8'($urandom_range(0, 14)));
            end else if (r < 86) begin
                for (int i = $urandom_range(1, 4); i > 0; i--)
                    push_byte(8'($urandom_range(0, 255)));
            end else if (r < 92) begin
                // broken preamble: a run of 0x02 then neither preamble byte
                for (int i = $urandom_range(1, 3); i > 0; i--)
                    push_byte(plcd_pkg::PREAMBLE_0);
                push_byte(8'($urandom_range(3, 255)));
            end else begin
                push_ticks($urandom_range(1, 3));
                push_byte(plcd_pkg::PREAMBLE_0);
                push_byte(plcd_pkg::PREAMBLE_1);
                for (int i = $urandom_range(0, 12); i > 0; i--)
                    push_byte(8'($urandom_range(0, 255)));
                push_ticks(tmo);
            end
        end
    endtask

    task automatic queue_directed();
        // tick while hunting is ignored
        push_ticks(1);
        // repeated 0x02 keeps the hunt armed; length 14 is short
        push_byte(plcd_pkg::PREAMBLE_0);
        push_byte(plcd_pkg::PREAMBLE_0);
        push_byte(plcd_pkg::PREAMBLE_1);
        push_byte(8'h0E);
        // zero length is short
        push_byte(plcd_pkg::PREAMBLE_0);
        push_byte(plcd_pkg::PREAMBLE_1);
        push_byte(8'h00);
        // broken preamble
        push_byte(plcd_pkg::PREAMBLE_0);
        push_byte(8'h07);
        // minimum length frame, checksum one below the true sum of 0x8F
        push_byte(plcd_pkg::PREAMBLE_0);
        push_byte(plcd_pkg::PREAMBLE_1);
        push_byte(plcd_pkg::MIN_FRAME);
        push_byte(8'h00);
        repeat (4) push_byte(8'hFF);
        repeat (4) push_byte(8'h00);
        push_byte(8'h80);
        push_byte(8'h01);
        push_byte(8'h8E);
    endtask

    task automatic wait_drained();
        do
            @(posedge aclk);
        while (rx_items.size() != 0 || s_valid || drain_pause || awaited_out.size() != 0);
        // allow for items still inside the block that cause no result
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_idle_timeout(logic [7:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        gen_timeout = value;
    endtask

    task automatic run_phase(int snd_pct, int rcv_pct, int budget);
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        queue_random(budget, gen_timeout);
        wait_drained();
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        queue_directed();
        run_phase(0, 0, 480);

        write_idle_timeout(8'd1);
        run_phase(81, 0, 500);

        write_idle_timeout(8'd255);
        run_phase(0, 81, 500);

        last_timeout = $urandom_range(2, 40);
        write_idle_timeout(8'(last_timeout));
        run_phase(7, 7, 500);

        repeat (8) @(posedge aclk);
        if (awaited_out.size() != 0) begin
            $error("%0d expected results never arrived", awaited_out.size());
            errors++;
        end
        $display("Covered %0d input transfers, %0d payload bytes and %0d verdicts",
                 n_in, n_payload, n_ok + n_bad_sum + n_short);
        $display("Verdicts: %0d ok, %0d bad checksum, %0d short; idle timeouts 10, 1, 255, %0d",
                 n_ok, n_bad_sum, n_short, last_timeout);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
